/* rtl/vrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants of the VLAN record pager.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int MAX_CLIENTS = 16;
    localparam int REC_AW      = $clog2(MAX_RECORDS);
    localparam int CLI_AW      = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int TOT_W       = $clog2(MAX_RECORDS + 1);

    typedef enum logic [2:0] {
        ST_RECORD     = 3'd0,
        ST_INVALID    = 3'd1,
        ST_NO_MORE    = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_LOADED     = 3'd4,
        ST_STORE_FULL = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_REPLY   = 2'd2
    } op_t;

    // classified request handed from the front part to the back part
    typedef struct packed {
        op_t         op;
        status_t     status;
        logic [11:0] vlan;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] port;
        logic [6:0]  count;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_FIND, BK_SHIFT_RD, BK_SHIFT_WR, BK_PUT, BK_SCAN, BK_SCAN_END,
        BK_EMIT_RD, BK_EMIT, BK_REPLY, BK_CURSOR
    } back_state_t;

endpackage

/* rtl/vlan_record_pager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlan_record_pager
// Sorted VLAN record store with per-client paged reads.
//
// channel   dir  payload
// s_axis    in   command in tuser, vlan/mac/ip/port/count in tdata
// m_axis    out  status in tuser, vlan/mac in tdata, last in tlast
//
// One request at a time. A load moves each record of the insertion shift
// via BK_FIND, BK_SHIFT_RD, BK_SHIFT_WR; a request scans the client table,
// then reads each emitted record in BK_EMIT_RD (store memory read port).
// Reset clears the record count and the client valid bits.
// A stalled result holds the back part; input stays blocked meanwhile.
// ----------------------------------------------------------------------------
module vlan_record_pager
    import vrp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [119:0]  s_tdata,  // vlan_id, mac_address, client_ip, client_port,
                                    // requested_count, zero fill
    input  logic          s_tuser,  // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,  // record_vlan, record_mac, zero fill
    output logic [2:0]    m_tuser,  // status
    output logic          m_tlast   // last
);

    logic        job_valid;
    logic        job_take;
    job_t        job;
    logic [TOT_W-1:0] total;
    logic        busy;
    logic [11:0] r_vlan;
    logic [47:0] r_mac;

    vrp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_command(s_tuser),
        .in_vlan   (s_tdata[11:0]),
        .in_mac    (s_tdata[59:12]),
        .in_ip     (s_tdata[91:60]),
        .in_port   (s_tdata[107:92]),
        .in_count  (s_tdata[115:108]),
        .total     (total),
        .busy      (busy),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    vrp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .total     (total),
        .busy      (busy),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_status(m_tuser),
        .res_vlan  (r_vlan),
        .res_mac   (r_mac),
        .res_last  (m_tlast)
    );

    assign m_tdata = {4'd0, r_mac, r_vlan};

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= TOT_W'(MAX_RECORDS)) else $error("record count overflow");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !busy && !job_valid) else $error("accept while busy");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

endmodule

/* rtl/vrp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_front
// Accepts input requests, checks the count and queues classified jobs.
// ----------------------------------------------------------------------------
module vrp_front
    import vrp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_command,
    input  logic [11:0]   in_vlan,
    input  logic [47:0]   in_mac,
    input  logic [31:0]   in_ip,
    input  logic [15:0]   in_port,
    input  logic [7:0]    in_count,
    input  logic [TOT_W-1:0] total,
    input  logic          busy,
    output logic          job_valid,
    input  logic          job_take,
    output job_t          job
);

    job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rp_reg;
    logic       wp_reg;
    job_t       nj;
    logic       acc;
    logic       pend_reg;

    // one request in flight: the count test needs the total it leaves behind
    assign in_ready  = (cnt_reg == 2'd0) && !busy && !pend_reg;
    assign acc       = in_valid && in_ready;
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rp_reg];

    always_comb begin
        nj        = '0;
        nj.vlan   = in_vlan;
        nj.mac    = in_mac;
        nj.ip     = in_ip;
        nj.port   = in_port;
        nj.count  = in_count[6:0];
        if (!in_command) begin
            nj.op = OP_LOAD;
        end else if (in_count[7] || in_count == 8'd0) begin
            nj.op     = OP_REPLY;
            nj.status = ST_INVALID;
        end else if ({1'b0, in_count[6:0]} >= 8'(total)) begin
            nj.op     = OP_REPLY;
            nj.status = ST_NO_MORE;
        end else begin
            nj.op = OP_REQUEST;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            q_reg[wp_reg] <= nj;
        end
        if (!aresetn) begin
            cnt_reg  <= '0;
            rp_reg   <= 1'b0;
            wp_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (acc) begin
                wp_reg <= !wp_reg;
            end
            if (job_take) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg  <= cnt_reg + 2'(acc) - 2'(job_take);
            pend_reg <= acc;
        end
    end

endmodule

/* rtl/vrp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_back
// Executes jobs: sorted insertion, client lookup and record paging.
// ----------------------------------------------------------------------------
module vrp_back
    import vrp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_take,
    input  job_t          job,
    output logic [TOT_W-1:0] total,
    output logic          busy,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [2:0]    res_status,
    output logic [11:0]   res_vlan,
    output logic [47:0]   res_mac,
    output logic          res_last
);

    logic [11:0] sv_mem [MAX_RECORDS];
    logic [47:0] sm_mem [MAX_RECORDS];
    logic [11:0] rd_vlan_reg;
    logic [47:0] rd_mac_reg;

    logic [MAX_CLIENTS-1:0] cv_reg, cv_next;
    logic [31:0]     ca_reg [MAX_CLIENTS];
    logic [15:0]     cp_reg [MAX_CLIENTS];
    logic [REC_AW-1:0] cc_reg [MAX_CLIENTS];

    back_state_t st_reg, st_next;
    job_t        j_reg, j_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic [TOT_W-1:0] pos_reg, pos_next;
    logic [CLI_AW:0]  ci_reg, ci_next;
    logic [CLI_AW-1:0] slot_reg, slot_next;
    logic [CLI_AW-1:0] free_reg, free_next;
    logic        hit_reg, hit_next, fr_reg, fr_next;
    logic [TOT_W-1:0] cur_reg, cur_next;
    logic [6:0]  left_reg, left_next;
    logic        ov_reg, ov_next;
    logic [2:0]  os_reg, os_next;
    logic [11:0] ovl_reg, ovl_next;
    logic [47:0] omc_reg, omc_next;
    logic        ol_reg, ol_next;

    logic        rd_en;
    logic [REC_AW-1:0] rd_addr;
    logic        wr_en;
    logic [REC_AW-1:0] wr_addr;
    logic [11:0] wr_vlan;
    logic [47:0] wr_mac;
    logic        cl_new, cl_cur;
    logic [CLI_AW-1:0] ci_idx;
    logic        cslot_free;

    assign total      = tot_reg;
    assign busy       = st_reg != BK_IDLE || ov_reg;
    assign res_valid  = ov_reg;
    assign res_status = os_reg;
    assign res_vlan   = ovl_reg;
    assign res_mac    = omc_reg;
    assign res_last   = ol_reg;
    assign ci_idx     = ci_reg[CLI_AW-1:0];
    assign cslot_free = !cv_reg[ci_idx];

    always_comb begin
        st_next   = st_reg;
        j_next    = j_reg;
        tot_next  = tot_reg;
        pos_next  = pos_reg;
        ci_next   = ci_reg;
        slot_next = slot_reg;
        free_next = free_reg;
        hit_next  = hit_reg;
        fr_next   = fr_reg;
        cur_next  = cur_reg;
        left_next = left_reg;
        ov_next   = ov_reg && !res_ready;
        os_next   = os_reg;
        ovl_next  = ovl_reg;
        omc_next  = omc_reg;
        ol_next   = ol_reg;
        cv_next   = cv_reg;
        job_take  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_vlan   = j_reg.vlan;
        wr_mac    = j_reg.mac;
        cl_new    = 1'b0;
        cl_cur    = 1'b0;
        unique case (st_reg)
            BK_IDLE: begin
                if (job_valid && !ov_reg) begin
                    job_take = 1'b1;
                    j_next   = job;
                    unique case (job.op)
                        OP_LOAD: begin
                            if (tot_reg >= TOT_W'(MAX_RECORDS)) begin
                                os_next = ST_STORE_FULL;
                                st_next = BK_REPLY;
                            end else begin
                                pos_next = tot_reg;
                                st_next  = BK_FIND;
                            end
                        end
                        OP_REQUEST: begin
                            ci_next  = '0;
                            hit_next = 1'b0;
                            fr_next  = 1'b0;
                            st_next  = BK_SCAN;
                        end
                        default: begin
                            os_next = job.status;
                            st_next = BK_REPLY;
                        end
                    endcase
                end
            end
            BK_FIND: begin
                if (pos_reg == '0) begin
                    st_next = BK_PUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = REC_AW'(pos_reg - 1'b1);
                    st_next = BK_SHIFT_RD;
                end
            end
            BK_SHIFT_RD: begin
                st_next = BK_SHIFT_WR;
            end
            BK_SHIFT_WR: begin
                if (rd_vlan_reg > j_reg.vlan) begin
                    wr_en    = 1'b1;
                    wr_addr  = REC_AW'(pos_reg);
                    wr_vlan  = rd_vlan_reg;
                    wr_mac   = rd_mac_reg;
                    pos_next = pos_reg - 1'b1;
                    st_next  = BK_FIND;
                end else begin
                    st_next = BK_PUT;
                end
            end
            BK_PUT: begin
                wr_en    = 1'b1;
                wr_addr  = REC_AW'(pos_reg);
                tot_next = tot_reg + 1'b1;
                os_next  = ST_LOADED;
                st_next  = BK_REPLY;
            end
            BK_SCAN: begin
                if (cv_reg[ci_idx]) begin
                    if (!hit_reg && ca_reg[ci_idx] == j_reg.ip
                        && cp_reg[ci_idx] == j_reg.port) begin
                        hit_next  = 1'b1;
                        slot_next = ci_idx;
                    end
                end else if (!fr_reg && cslot_free) begin
                    fr_next   = 1'b1;
                    free_next = ci_idx;
                end
                ci_next = ci_reg + 1'b1;
                if (ci_reg == (CLI_AW + 1)'(MAX_CLIENTS - 1)) begin
                    st_next = BK_SCAN_END;
                end
            end
            BK_SCAN_END: begin
                if (hit_reg) begin
                    cur_next = (TOT_W'(cc_reg[slot_reg]) >= tot_reg) ? '0
                                                                    : TOT_W'(cc_reg[slot_reg]);
                    left_next = j_reg.count;
                    st_next   = BK_EMIT_RD;
                end else if (fr_reg) begin
                    cl_new              = 1'b1;
                    slot_next           = free_reg;
                    cv_next[free_reg]   = 1'b1;
                    cur_next            = '0;
                    left_next           = j_reg.count;
                    st_next             = BK_EMIT_RD;
                end else begin
                    os_next = ST_TABLE_FULL;
                    st_next = BK_REPLY;
                end
            end
            BK_EMIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = REC_AW'(cur_reg);
                st_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (!ov_reg || res_ready) begin
                    ov_next   = 1'b1;
                    os_next   = ST_RECORD;
                    ovl_next  = rd_vlan_reg;
                    omc_next  = rd_mac_reg;
                    left_next = left_reg - 1'b1;
                    cur_next  = cur_reg + 1'b1;
                    if (left_reg == 7'd1 || cur_reg + 1'b1 >= tot_reg) begin
                        ol_next = 1'b1;
                        st_next = BK_CURSOR;
                    end else begin
                        ol_next = 1'b0;
                        st_next = BK_EMIT_RD;
                    end
                end
            end
            BK_CURSOR: begin
                cl_cur  = 1'b1;
                st_next = BK_IDLE;
            end
            BK_REPLY: begin
                if (!ov_reg || res_ready) begin
                    ov_next  = 1'b1;
                    ovl_next = '0;
                    omc_next = '0;
                    ol_next  = 1'b1;
                    st_next  = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sv_mem[wr_addr] <= wr_vlan;
            sm_mem[wr_addr] <= wr_mac;
        end
        if (rd_en) begin
            rd_vlan_reg <= sv_mem[rd_addr];
            rd_mac_reg  <= sm_mem[rd_addr];
        end
        if (cl_new) begin
            ca_reg[free_reg] <= j_reg.ip;
            cp_reg[free_reg] <= j_reg.port;
        end
        if (cl_cur) begin
            cc_reg[slot_reg] <= (cur_reg >= tot_reg) ? '0 : REC_AW'(cur_reg);
        end
    end

    always_ff @(posedge aclk) begin
        j_reg    <= j_next;
        pos_reg  <= pos_next;
        ci_reg   <= ci_next;
        slot_reg <= slot_next;
        free_reg <= free_next;
        hit_reg  <= hit_next;
        fr_reg   <= fr_next;
        cur_reg  <= cur_next;
        left_reg <= left_next;
        os_reg   <= os_next;
        ovl_reg  <= ovl_next;
        omc_reg  <= omc_next;
        ol_reg   <= ol_next;
        if (!aresetn) begin
            st_reg  <= BK_IDLE;
            tot_reg <= '0;
            cv_reg  <= '0;
            ov_reg  <= 1'b0;
        end else begin
            st_reg  <= st_next;
            tot_reg <= tot_next;
            cv_reg  <= cv_next;
            ov_reg  <= ov_next;
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads and client page requests into the VLAN record pager and
// checks every result against a local model of the sorted store and the
// client cursor table. Directed rows first, then random traffic.
// ----------------------------------------------------------------------------
module testbench;
    import vrp_pkg::*;

    typedef struct {
        logic        cmd;
        logic [11:0] vlan;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] port;
        logic [7:0]  count;
        logic        typed;
        status_t     want;
    } request_t;

    typedef struct {
        status_t     status;
        logic [11:0] vlan;
        logic [47:0] mac;
        logic        last;
    } reply_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [119:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;
    logic [2:0]    m_tuser;
    logic          m_tlast;

    logic [11:0] rec_vlan [MAX_RECORDS];
    logic [47:0] rec_mac [MAX_RECORDS];
    int          rec_count;
    logic        cl_valid [MAX_CLIENTS];
    logic [31:0] cl_ip [MAX_CLIENTS];
    logic [15:0] cl_port [MAX_CLIENTS];
    int          cl_cursor [MAX_CLIENTS];

    reply_t   pending_replies[$];
    request_t directed[$];
    int       errors;
    int       idle_cycles = 0;
    bit       calm;
    bit       timed_out = 1'b0;

    vlan_record_pager i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void push_reply(status_t st, logic [11:0] v, logic [47:0] m,
                                       logic l);
        reply_t r;
        r.status = st;
        r.vlan   = v;
        r.mac    = m;
        r.last   = l;
        pending_replies.push_back(r);
    endfunction

    function automatic void page_records(request_t rq);
        int n;
        int slot;
        int free_slot;
        int cur;
        int sent;
        n = $signed(rq.count);
        slot = -1;
        free_slot = -1;
        sent = 0;
        if (rq.cmd == 1'b0) begin
            if (rec_count >= MAX_RECORDS) begin
                push_reply(ST_STORE_FULL, '0, '0, 1'b1);
                return;
            end
            cur = rec_count;
            while (cur > 0 && rec_vlan[cur - 1] > rq.vlan) cur--;
            for (int i = rec_count; i > cur; i--) begin
                rec_vlan[i] = rec_vlan[i - 1];
                rec_mac[i]  = rec_mac[i - 1];
            end
            rec_vlan[cur] = rq.vlan;
            rec_mac[cur]  = rq.mac;
            rec_count++;
            push_reply(ST_LOADED, '0, '0, 1'b1);
            return;
        end
        if (n <= 0) begin
            push_reply(ST_INVALID, '0, '0, 1'b1);
            return;
        end
        if (n >= rec_count) begin
            push_reply(ST_NO_MORE, '0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            if (cl_valid[i]) begin
                if (slot < 0 && cl_ip[i] == rq.ip && cl_port[i] == rq.port) slot = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (slot < 0) begin
            if (free_slot < 0) begin
                push_reply(ST_TABLE_FULL, '0, '0, 1'b1);
                return;
            end
            slot = free_slot;
            cl_valid[slot]  = 1'b1;
            cl_ip[slot]     = rq.ip;
            cl_port[slot]   = rq.port;
            cl_cursor[slot] = 0;
        end
        cur = cl_cursor[slot];
        if (cur >= rec_count) cur = 0;
        while (sent < n && cur < rec_count) begin
            sent++;
            push_reply(ST_RECORD, rec_vlan[cur], rec_mac[cur],
                       (sent == n || cur + 1 == rec_count));
            cur++;
        end
        if (cur >= rec_count) cur = 0;
        cl_cursor[slot] = cur;
    endfunction

    task automatic send_request(request_t rq);
        int gap;
        int depth;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.cmd;
        s_tdata  <= {4'd0, rq.count, rq.port, rq.ip, rq.mac, rq.vlan};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        depth = pending_replies.size();
        page_records(rq);
        if (rq.typed && pending_replies[depth].status != rq.want) begin
            $error("status row: expected %0d actual %0d", rq.want,
                   pending_replies[depth].status);
            errors++;
        end
        @(negedge aclk);
    endtask

    function automatic request_t make_load(logic [11:0] v, logic [47:0] m);
        request_t rq;
        rq = '{1'b0, v, m, $urandom, 16'($urandom), 8'($urandom), 1'b0, ST_LOADED};
        return rq;
    endfunction

    function automatic request_t make_page(logic [31:0] ip, logic [15:0] port,
                                           logic [7:0] n);
        request_t rq;
        rq = '{1'b1, 12'($urandom), 48'({$urandom, $urandom}), ip, port, n, 1'b0,
               ST_RECORD};
        return rq;
    endfunction

    function automatic request_t typed_row(request_t rq, status_t st);
        rq.typed = 1'b1;
        rq.want  = st;
        return rq;
    endfunction

    always @(posedge aclk) begin
        reply_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result: status %0d", m_tuser);
                errors++;
            end else begin
                exp = pending_replies.pop_front();
                if (m_tuser != exp.status) begin
                    $error("status: expected %0d actual %0d", exp.status, m_tuser);
                    errors++;
                end
                if (m_tdata[11:0] != exp.vlan) begin
                    $error("record_vlan: expected %h actual %h", exp.vlan, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[59:12] != exp.mac) begin
                    $error("record_mac: expected %h actual %h", exp.mac, m_tdata[59:12]);
                    errors++;
                end
                if (m_tlast != exp.last) begin
                    $error("last: expected %0d actual %0d", exp.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out) begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        request_t rq;
        logic [31:0] ips [4];
        logic [15:0] ports [4];
        int sel;
        errors = 0;
        calm = 1'b0;
        rec_count = 0;
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            cl_valid[i] = 1'b0;
            cl_cursor[i] = 0;
        end
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed.push_back(typed_row(make_page(32'h0, 16'h0, 8'd1), ST_NO_MORE));
        directed.push_back(typed_row(make_page(32'h1, 16'h1, 8'd0), ST_INVALID));
        directed.push_back(typed_row(make_page(32'h1, 16'h1, 8'h80), ST_INVALID));
        directed.push_back(typed_row(make_page(32'h1, 16'h1, 8'hF7), ST_INVALID));
        directed.push_back(typed_row(make_load(12'hFFF, 48'hFFFF_FFFF_FFFF), ST_LOADED));
        directed.push_back(typed_row(make_page(32'h1, 16'h1, 8'd1), ST_NO_MORE));
        directed.push_back(typed_row(make_load(12'h000, 48'h0), ST_LOADED));
        directed.push_back(make_load(12'h800, 48'h8000_0000_0001));
        directed.push_back(make_load(12'h800, 48'h0000_0000_0002));
        directed.push_back(make_load(12'h001, 48'h5555_AAAA_5555));
        directed.push_back(make_page(32'hFFFF_FFFF, 16'hFFFF, 8'd2));
        directed.push_back(make_page(32'hFFFF_FFFF, 16'hFFFF, 8'd4));
        directed.push_back(make_page(32'hFFFF_FFFF, 16'hFFFF, 8'd4));
        directed.push_back(make_page(32'h0, 16'h0, 8'd3));
        directed.push_back(make_page(32'hFFFF_FFFF, 16'h0, 8'h7F));
        foreach (directed[i]) send_request(directed[i]);

        for (int i = 0; i < 4; i++) begin
            ips[i] = $urandom;
            ports[i] = 16'($urandom);
        end
        for (int k = 0; k < 320; k++) begin
            if (k > 270) calm = 1'b1;
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                rq = make_load(12'($urandom), 48'({$urandom, $urandom}));
            end else if (sel < 8) begin
                rq = make_page(ips[$urandom_range(0, 3)], ports[$urandom_range(0, 3)],
                               8'($urandom_range(1, (rec_count > 1) ? rec_count - 1 : 1)));
                if ($urandom_range(0, 9) == 0) rq.count = 8'd1;
            end else if (sel == 8) begin
                rq = make_page($urandom, 16'($urandom), 8'($urandom_range(1, 12)));
            end else begin
                rq = make_page($urandom, 16'($urandom), 8'($urandom));
            end
            send_request(rq);
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/vrp_pkg.sv
rtl/vrp_front.sv
rtl/vrp_back.sv
rtl/vlan_record_pager.sv
tb/testbench.sv
